/* rtl/core/dlr_pkg.sv */
// ----------------------------------------------------------------------------
// dlr_pkg : shared types and arithmetic for the dielectric scatter block
// Fixed-point helpers, the pipeline context and the set-up FSM states.
// ----------------------------------------------------------------------------
package dlr_pkg;

  localparam int unsigned FB = 16;                  // fraction bits
  localparam logic [63:0] ONE_Q  = 64'(1) << FB;
  localparam logic [63:0] HALF_Q = 64'(1) << (FB - 1);

  // Set-up sequencer, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_INIT = 5'b00010,
    ST_ETA  = 5'b00100,
    ST_R0F  = 5'b01000,
    ST_R0B  = 5'b10000
  } cu_state_e;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] r;
  } sqrt_t;

  // Everything a ray hit carries down the pipeline
  typedef struct packed {
    logic [2:0][31:0]        hit;
    logic [2:0][17:0]        nrm;
    logic                    front;
    logic [15:0]             rnd;
    logic [2:0][31:0]        mag;
    logic [2:0]              dneg;
    logic [31:0]             m;
    logic                    zero;
    logic [2:0][63:0]        msq;
    logic [63:0]             ax;
    logic [63:0]             ar;
    logic [32:0]             len;
    logic [2:0][48:0]        rem;
    logic [2:0][16:0]        quo;
    logic [2:0][17:0]        u;
    logic [18:0]             eta;
    logic [16:0]             r0;
    logic [2:0][19:0]        mun;
    logic signed [21:0]      dun;
    logic signed [17:0]      cs;
    logic [17:0]             xs;
    logic [16:0]             cc;
    logic [2:0][18:0]        mcn;
    logic [2:0][21:0]        mdn;
    logic [2:0][19:0]        t;
    logic [2:0][31:0]        rfl;
    logic [16:0]             p;
    logic [2:0][31:0]        perp;
    logic [47:0]             lsq;
    logic [16:0]             pr;
    logic                    beats;
    logic [63:0]             bx;
    logic [63:0]             br;
    logic [63:0]             cx;
    logic [63:0]             cr;
    logic                    cannot;
    logic [2:0][23:0]        mnp;
    logic [2:0][31:0]        res;
    logic                    refl;
  } ctx_t;

  // Product rounded to FB fraction bits, half away from zero
  function automatic logic signed [47:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] p;
    logic [47:0] q;
    ma = a[31] ? (~a + 32'd1) : a;
    mb = b[31] ? (~b + 32'd1) : b;
    p  = 64'(ma) * 64'(mb);
    p  = (p + HALF_Q) >> FB;
    q  = p[47:0];
    return (a[31] != b[31]) ? $signed(~q + 48'd1) : $signed(q);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Clamp a non-negative product to 1.0
  function automatic logic [16:0] min_one(input logic signed [47:0] v);
    if (v > $signed(ONE_Q[47:0])) return ONE_Q[16:0];
    return v[16:0];
  endfunction

  // One digit of the truncating square root
  function automatic sqrt_t sqrt_step(input logic [63:0] x, input logic [63:0] r,
                                      input logic [63:0] bitv);
    sqrt_t s;
    if (x >= r + bitv) begin
      s.x = x - (r + bitv);
      s.r = (r >> 1) + bitv;
    end else begin
      s.x = x;
      s.r = r >> 1;
    end
    return s;
  endfunction

endpackage

/* rtl/core/dielectric_reflect_refract.sv */
// ----------------------------------------------------------------------------
// dielectric_reflect_refract : dielectric scatter, Schlick Fresnel choice
// Normalizes the incoming direction, chooses reflection or refraction and
// emits the scattered ray in signed Q16.16.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------
//  hit in    | start_i, busy_o           | dir_*, normal_*, front_face,
//            |                           | random_value, hit_*
//  result    | result_valid_o (strobe)   | origin_*, out_dir_*, was_reflected
//  config    | cfg_valid_i, cfg_ready_o  | cfg_data_i (refraction index)
//
//  One transaction enters per cycle while busy_o is low; results leave in
//  order, one per cycle. Most stages are the 32-digit length square root,
//  the 17-step quotient chain and the 22-digit refraction root. After reset
//  and after each index write, a shared serial divider works out front-face
//  eta and r0 for both faces (back-face eta is the clamped index); busy_o is
//  high meanwhile. The result side cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module dielectric_reflect_refract import dlr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] dir_x_i,
  input  logic [31:0] dir_y_i,
  input  logic [31:0] dir_z_i,
  input  logic [17:0] normal_x_i,
  input  logic [17:0] normal_y_i,
  input  logic [17:0] normal_z_i,
  input  logic        front_face_i,
  input  logic [15:0] random_value_i,
  input  logic [31:0] hit_x_i,
  input  logic [31:0] hit_y_i,
  input  logic [31:0] hit_z_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [18:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [31:0] origin_x_o,
  output logic [31:0] origin_y_o,
  output logic [31:0] origin_z_o,
  output logic [31:0] out_dir_x_o,
  output logic [31:0] out_dir_y_o,
  output logic [31:0] out_dir_z_o,
  output logic        was_reflected_o
);

  // Stage map
  localparam int S_ABS   = 1;
  localparam int S_MAX   = 2;
  localparam int S_SH    = 3;   // five normalizing shift steps
  localparam int S_SQR   = 8;
  localparam int S_SUM   = 9;
  localparam int S_SQA   = 10;  // 32 root digits
  localparam int S_DIVI  = 42;
  localparam int S_DIV   = 43;  // 17 quotient bits
  localparam int S_UNIT  = 60;
  localparam int S_DOT   = 61;
  localparam int S_COS   = 62;
  localparam int S_PROD  = 63;
  localparam int S_P1    = 64;
  localparam int S_P2    = 65;
  localparam int S_P3    = 66;
  localparam int S_P4    = 67;
  localparam int S_PR    = 68;
  localparam int S_BEAT  = 69;
  localparam int S_SQB   = 70;  // 22 digits, sine and parallel roots
  localparam int S_TIR   = 92;
  localparam int S_OUT   = 93;
  localparam int NSTG    = 94;

  // --------------------------------------------------------------------------
  // Set-up: index register, clamped index, per-face eta and r0
  // --------------------------------------------------------------------------
  cu_state_e   state_q, state_d;
  logic [18:0] ior_q, ior_d;
  logic [18:0] iorc;
  logic [35:0] drem_q, drem_d;
  logic [18:0] dden_q, dden_d;
  logic [16:0] dquo_q, dquo_d;
  logic [4:0]  dcnt_q, dcnt_d;
  logic [16:0] eta_f_q, eta_f_d;
  logic [16:0] r0f_q, r0f_d;
  logic [16:0] r0b_q, r0b_d;
  logic [35:0] dv;
  logic        dge;
  logic [35:0] drem_nx;
  logic [16:0] dquo_nx;
  logic [16:0] r0sq;

  always_comb begin
    if (ior_q < ONE_Q[18:0]) iorc = ONE_Q[18:0];
    else if (ior_q > 19'(4 * ONE_Q)) iorc = 19'(4 * ONE_Q);
    else iorc = ior_q;
  end

  // one restoring-division bit per cycle
  assign dv      = 36'(dden_q) << dcnt_q;
  assign dge     = drem_q >= dv;
  assign drem_nx = dge ? (drem_q - dv) : drem_q;
  assign dquo_nx = dquo_q | (17'(dge) << dcnt_q);
  assign r0sq    = min_one(mulq(32'(dquo_nx), 32'(dquo_nx)));

  always_comb begin
    state_d = state_q;
    ior_d   = ior_q;
    drem_d  = drem_nx;
    dden_d  = dden_q;
    dquo_d  = dquo_nx;
    dcnt_d  = dcnt_q - 5'd1;
    eta_f_d = eta_f_q;
    r0f_d   = r0f_q;
    r0b_d   = r0b_q;
    unique case (state_q)
      ST_IDLE: begin
        drem_d = drem_q;
        dquo_d = dquo_q;
        dcnt_d = dcnt_q;
        if (cfg_valid_i) begin
          ior_d   = cfg_data_i;
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        drem_d  = (36'(1) << (2 * FB)) + 36'(iorc >> 1);
        dden_d  = iorc;
        dquo_d  = '0;
        dcnt_d  = 5'(FB);
        state_d = ST_ETA;
      end
      ST_ETA: begin
        if (dcnt_q == 5'd0) begin
          eta_f_d = dquo_nx;
          // front face: |1-eta| = 1-eta as eta <= 1
          drem_d  = (36'(ONE_Q[16:0] - dquo_nx) << FB)
                  + 36'((ONE_Q[18:0] + 19'(dquo_nx)) >> 1);
          dden_d  = ONE_Q[18:0] + 19'(dquo_nx);
          dquo_d  = '0;
          dcnt_d  = 5'(FB);
          state_d = ST_R0F;
        end
      end
      ST_R0F: begin
        if (dcnt_q == 5'd0) begin
          r0f_d   = r0sq;
          drem_d  = (36'(iorc - ONE_Q[18:0]) << FB) + 36'((ONE_Q[18:0] + iorc) >> 1);
          dden_d  = ONE_Q[18:0] + iorc;
          dquo_d  = '0;
          dcnt_d  = 5'(FB);
          state_d = ST_R0B;
        end
      end
      ST_R0B: begin
        if (dcnt_q == 5'd0) begin
          r0b_d   = r0sq;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      ior_q   <= 19'(ONE_Q);
    end else begin
      state_q <= state_d;
      ior_q   <= ior_d;
    end
  end

  always_ff @(posedge clk_i) begin
    drem_q  <= drem_d;
    dden_q  <= dden_d;
    dquo_q  <= dquo_d;
    dcnt_q  <= dcnt_d;
    eta_f_q <= eta_f_d;
    r0f_q   <= r0f_d;
    r0b_q   <= r0b_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);

  // --------------------------------------------------------------------------
  // Ray pipeline: no back-pressure, valid bits just shift
  // --------------------------------------------------------------------------
  ctx_t st_d [NSTG];
  ctx_t st_q [NSTG];
  logic vld_q [NSTG];

  // capture
  always_comb begin
    st_d[0]       = '0;
    st_d[0].mag   = {dir_z_i, dir_y_i, dir_x_i};
    st_d[0].nrm   = {normal_z_i, normal_y_i, normal_x_i};
    st_d[0].hit   = {hit_z_i, hit_y_i, hit_x_i};
    st_d[0].front = front_face_i;
    st_d[0].rnd   = random_value_i;
  end

  // magnitudes and signs
  always_comb begin
    st_d[S_ABS] = st_q[S_ABS-1];
    for (int i = 0; i < 3; i++) begin
      st_d[S_ABS].dneg[i] = st_q[S_ABS-1].mag[i][31];
      st_d[S_ABS].mag[i]  = st_q[S_ABS-1].mag[i][31] ? (~st_q[S_ABS-1].mag[i] + 32'd1)
                                                      : st_q[S_ABS-1].mag[i];
    end
  end

  // largest magnitude
  always_comb begin
    logic [31:0] mx;
    st_d[S_MAX] = st_q[S_MAX-1];
    mx = st_q[S_MAX-1].mag[0];
    if (st_q[S_MAX-1].mag[1] > mx) mx = st_q[S_MAX-1].mag[1];
    if (st_q[S_MAX-1].mag[2] > mx) mx = st_q[S_MAX-1].mag[2];
    st_d[S_MAX].m    = mx;
    st_d[S_MAX].zero = (mx == 32'd0);
  end

  // binary normalizing shift until the peak reaches bit 30
  for (genvar j = 0; j < 5; j++) begin : g_norm
    localparam int K = 16 >> j;
    always_comb begin
      st_d[S_SH+j] = st_q[S_SH+j-1];
      if ((st_q[S_SH+j-1].m >> (31 - K)) == 32'd0) begin
        st_d[S_SH+j].m = st_q[S_SH+j-1].m << K;
        for (int i = 0; i < 3; i++)
          st_d[S_SH+j].mag[i] = st_q[S_SH+j-1].mag[i] << K;
      end
    end
  end

  always_comb begin
    st_d[S_SQR] = st_q[S_SQR-1];
    for (int i = 0; i < 3; i++)
      st_d[S_SQR].msq[i] = 64'(st_q[S_SQR-1].mag[i]) * 64'(st_q[S_SQR-1].mag[i]);
  end

  always_comb begin
    st_d[S_SUM]    = st_q[S_SUM-1];
    st_d[S_SUM].ax = st_q[S_SUM-1].msq[0] + st_q[S_SUM-1].msq[1] + st_q[S_SUM-1].msq[2];
    st_d[S_SUM].ar = '0;
  end

  // length root, one digit a stage
  for (genvar j = 0; j < 32; j++) begin : g_sqa
    always_comb begin
      sqrt_t s;
      st_d[S_SQA+j]    = st_q[S_SQA+j-1];
      s = sqrt_step(st_q[S_SQA+j-1].ax, st_q[S_SQA+j-1].ar, 64'(1) << (62 - 2 * j));
      st_d[S_SQA+j].ax = s.x;
      st_d[S_SQA+j].ar = s.r;
    end
  end

  // dividend with half-divisor rounding
  always_comb begin
    logic [32:0] ln;
    st_d[S_DIVI] = st_q[S_DIVI-1];
    ln = st_q[S_DIVI-1].ar[32:0];
    st_d[S_DIVI].len = ln;
    for (int i = 0; i < 3; i++) begin
      st_d[S_DIVI].rem[i] = (49'(st_q[S_DIVI-1].mag[i]) << FB) + 49'(ln >> 1);
      st_d[S_DIVI].quo[i] = '0;
    end
  end

  // three quotient lanes, one bit a stage
  for (genvar j = 0; j <= FB; j++) begin : g_div
    localparam int B = FB - j;
    always_comb begin
      logic [48:0] dq;
      st_d[S_DIV+j] = st_q[S_DIV+j-1];
      dq = 49'(st_q[S_DIV+j-1].len) << B;
      for (int i = 0; i < 3; i++) begin
        if (st_q[S_DIV+j-1].rem[i] >= dq) begin
          st_d[S_DIV+j].rem[i]    = st_q[S_DIV+j-1].rem[i] - dq;
          st_d[S_DIV+j].quo[i][B] = 1'b1;
        end
      end
    end
  end

  // unit vector, face constants
  always_comb begin
    logic [17:0] q;
    st_d[S_UNIT] = st_q[S_UNIT-1];
    for (int i = 0; i < 3; i++) begin
      q = 18'(st_q[S_UNIT-1].quo[i]);
      if (q > ONE_Q[17:0]) q = ONE_Q[17:0];
      st_d[S_UNIT].u[i] = st_q[S_UNIT-1].dneg[i] ? (~q + 18'd1) : q;
    end
    st_d[S_UNIT].eta = st_q[S_UNIT-1].front ? 19'(eta_f_q) : iorc;
    st_d[S_UNIT].r0  = st_q[S_UNIT-1].front ? r0f_q : r0b_q;
  end

  always_comb begin
    st_d[S_DOT] = st_q[S_DOT-1];
    for (int i = 0; i < 3; i++)
      st_d[S_DOT].mun[i] = 20'(mulq(32'($signed(st_q[S_DOT-1].u[i])),
                                    32'($signed(st_q[S_DOT-1].nrm[i]))));
  end

  always_comb begin
    logic signed [21:0] dn;
    logic signed [21:0] nc;
    st_d[S_COS] = st_q[S_COS-1];
    dn = 22'($signed(st_q[S_COS-1].mun[0])) + 22'($signed(st_q[S_COS-1].mun[1]))
       + 22'($signed(st_q[S_COS-1].mun[2]));
    nc = -dn;
    if (nc > $signed(22'(ONE_Q))) nc = $signed(22'(ONE_Q));
    if (nc < -$signed(22'(ONE_Q))) nc = -$signed(22'(ONE_Q));
    st_d[S_COS].dun = dn;
    st_d[S_COS].cs  = 18'(nc);
    st_d[S_COS].xs  = 18'($signed(22'(ONE_Q)) - nc);
  end

  always_comb begin
    st_d[S_PROD]    = st_q[S_PROD-1];
    st_d[S_PROD].cc = min_one(mulq(32'(st_q[S_PROD-1].cs), 32'(st_q[S_PROD-1].cs)));
    st_d[S_PROD].p  = (st_q[S_PROD-1].xs > ONE_Q[17:0]) ? ONE_Q[16:0]
                                                        : st_q[S_PROD-1].xs[16:0];
    for (int i = 0; i < 3; i++) begin
      st_d[S_PROD].mcn[i] = 19'(mulq(32'(st_q[S_PROD-1].cs),
                                     32'($signed(st_q[S_PROD-1].nrm[i]))));
      st_d[S_PROD].mdn[i] = 22'(mulq(32'(st_q[S_PROD-1].dun),
                                     32'($signed(st_q[S_PROD-1].nrm[i]))));
    end
  end

  // sine root set-up, reflected direction, tangent sum, Schlick power
  always_comb begin
    st_d[S_P1]    = st_q[S_P1-1];
    st_d[S_P1].bx = (ONE_Q - 64'(st_q[S_P1-1].cc)) << FB;
    st_d[S_P1].br = '0;
    st_d[S_P1].p  = min_one(mulq(32'(st_q[S_P1-1].p), 32'(st_q[S_P1-1].xs)));
    for (int i = 0; i < 3; i++) begin
      st_d[S_P1].t[i]   = 20'($signed(st_q[S_P1-1].u[i])) + 20'($signed(st_q[S_P1-1].mcn[i]));
      st_d[S_P1].rfl[i] = sat32(64'($signed(st_q[S_P1-1].u[i]))
                              - 64'($signed(st_q[S_P1-1].mdn[i])) * 64'sd2);
    end
  end

  always_comb begin
    st_d[S_P2]   = st_q[S_P2-1];
    st_d[S_P2].p = min_one(mulq(32'(st_q[S_P2-1].p), 32'(st_q[S_P2-1].xs)));
    for (int i = 0; i < 3; i++)
      st_d[S_P2].perp[i] = sat32(64'(mulq(32'(st_q[S_P2-1].eta),
                                          32'($signed(st_q[S_P2-1].t[i])))));
  end

  always_comb begin
    logic [31:0] pm;
    st_d[S_P3]   = st_q[S_P3-1];
    st_d[S_P3].p = min_one(mulq(32'(st_q[S_P3-1].p), 32'(st_q[S_P3-1].xs)));
    for (int i = 0; i < 3; i++) begin
      pm = st_q[S_P3-1].perp[i][31] ? (~st_q[S_P3-1].perp[i] + 32'd1) : st_q[S_P3-1].perp[i];
      st_d[S_P3].msq[i] = 64'(pm) * 64'(pm);
    end
  end

  always_comb begin
    logic [63:0] sq;
    st_d[S_P4]     = st_q[S_P4-1];
    st_d[S_P4].p   = min_one(mulq(32'(st_q[S_P4-1].p), 32'(st_q[S_P4-1].xs)));
    sq = st_q[S_P4-1].msq[0] + st_q[S_P4-1].msq[1] + st_q[S_P4-1].msq[2];
    st_d[S_P4].lsq = 48'((sq + HALF_Q) >> FB);
  end

  always_comb begin
    logic [47:0] df;
    st_d[S_PR]    = st_q[S_PR-1];
    st_d[S_PR].pr = min_one(mulq(32'(ONE_Q[16:0] - st_q[S_PR-1].r0), 32'(st_q[S_PR-1].p)));
    df = (st_q[S_PR-1].lsq > ONE_Q[47:0]) ? (st_q[S_PR-1].lsq - ONE_Q[47:0])
                                          : (ONE_Q[47:0] - st_q[S_PR-1].lsq);
    st_d[S_PR].cx = 64'(df) << FB;
    st_d[S_PR].cr = '0;
  end

  always_comb begin
    logic [17:0] rv;
    st_d[S_BEAT] = st_q[S_BEAT-1];
    rv = 18'(st_q[S_BEAT-1].r0) + 18'(st_q[S_BEAT-1].pr);
    st_d[S_BEAT].beats = (64'(rv) << 16) > (64'(st_q[S_BEAT-1].rnd) << FB);
  end

  // sine and parallel roots side by side; both fit under 2^44
  for (genvar j = 0; j < 22; j++) begin : g_sqb
    always_comb begin
      sqrt_t sb;
      sqrt_t sc;
      st_d[S_SQB+j] = st_q[S_SQB+j-1];
      sb = sqrt_step(st_q[S_SQB+j-1].bx, st_q[S_SQB+j-1].br, 64'(1) << (42 - 2 * j));
      sc = sqrt_step(st_q[S_SQB+j-1].cx, st_q[S_SQB+j-1].cr, 64'(1) << (42 - 2 * j));
      st_d[S_SQB+j].bx = sb.x;
      st_d[S_SQB+j].br = sb.r;
      st_d[S_SQB+j].cx = sc.x;
      st_d[S_SQB+j].cr = sc.r;
    end
  end

  // total internal reflection test, parallel component
  always_comb begin
    st_d[S_TIR] = st_q[S_TIR-1];
    st_d[S_TIR].cannot = (36'(st_q[S_TIR-1].eta) * 36'(st_q[S_TIR-1].br[16:0]))
                       > (36'(1) << (2 * FB));
    for (int i = 0; i < 3; i++)
      st_d[S_TIR].mnp[i] = 24'(mulq(32'($signed(st_q[S_TIR-1].nrm[i])),
                                    32'(st_q[S_TIR-1].cr[20:0])));
  end

  always_comb begin
    st_d[S_OUT] = st_q[S_OUT-1];
    if (st_q[S_OUT-1].zero) begin
      st_d[S_OUT].res  = '0;
      st_d[S_OUT].refl = 1'b0;
    end else if (st_q[S_OUT-1].cannot || st_q[S_OUT-1].beats) begin
      st_d[S_OUT].res  = st_q[S_OUT-1].rfl;
      st_d[S_OUT].refl = 1'b1;
    end else begin
      for (int i = 0; i < 3; i++)
        st_d[S_OUT].res[i] = sat32(64'($signed(st_q[S_OUT-1].perp[i]))
                                 - 64'($signed(st_q[S_OUT-1].mnp[i])));
      st_d[S_OUT].refl = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSTG; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[0] <= start_i && !busy_o;
      for (int k = 1; k < NSTG; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  assign result_valid_o  = vld_q[S_OUT];
  assign origin_x_o      = st_q[S_OUT].hit[0];
  assign origin_y_o      = st_q[S_OUT].hit[1];
  assign origin_z_o      = st_q[S_OUT].hit[2];
  assign out_dir_x_o     = st_q[S_OUT].res[0];
  assign out_dir_y_o     = st_q[S_OUT].res[1];
  assign out_dir_z_o     = st_q[S_OUT].res[2];
  assign was_reflected_o = st_q[S_OUT].refl;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !vld_q[0])
    else $error("transaction taken while set-up busy");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> ##93 result_valid_o)
    else $error("result strobe missing at fixed latency");

  a_zero_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && st_q[S_OUT].zero) |->
      (!was_reflected_o && out_dir_x_o == 32'd0 && out_dir_y_o == 32'd0
       && out_dir_z_o == 32'd0))
    else $error("zero direction gave non-zero result");

endmodule

/* tb/dielectric_reflect_refract_test.sv */
// ----------------------------------------------------------------------------
// dielectric_reflect_refract_test : self-checking bench for dielectric scatter
// Drives ray hits through the hit-in port, sweeps the refraction index and
// checks every result against an in-bench fixed-point scatter predictor.
// ----------------------------------------------------------------------------

typedef longint unsigned u64_t;

typedef struct {
  logic [31:0] dir [3];
  logic [17:0] nrm [3];
  logic        front;
  logic [15:0] rnd;
  logic [31:0] hit [3];
} ray_hit_t;

typedef struct {
  logic [31:0] origin [3];
  logic [31:0] dir    [3];
  logic        refl;
} scatter_t;

class scatter_scoreboard;
  localparam longint ONE  = 64'sd65536;
  localparam u64_t   HALF = 64'd32768;

  logic [18:0] ior_reg;
  scatter_t    scatter_q[$];
  int          mismatches;
  int          n_hits;
  int          n_refl;
  int          n_results;

  function new();
    ior_reg = 19'd65536;
  endfunction

  function u64_t umag(longint v);
    return v < 0 ? u64_t'(-v) : u64_t'(v);
  endfunction

  function longint qmul(longint a, longint b);
    u64_t p;
    p = umag(a) * umag(b);
    p = (p + HALF) >> 16;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function u64_t root(u64_t x);
    u64_t r;
    u64_t b;
    r = 0;
    b = u64_t'(1) << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Fixed-point dielectric scatter of one hit
  function scatter_t scatter(ray_hit_t h);
    scatter_t o;
    longint d[3], n[3], u[3], res[3], perp[3];
    u64_t   mag[3], m, sumsq, len, q, num, den, sn, sq, lensq, diff, par;
    longint ior, eta, dun, cs, sin2, r0l, r0, x, p, refl, t;
    int     s;
    bit     cannot, beats;
    m = 0; sumsq = 0; sq = 0; s = 0;
    o.refl = 1'b0;
    for (int i = 0; i < 3; i++) begin
      d[i] = longint'($signed(h.dir[i]));
      n[i] = longint'($signed(h.nrm[i]));
      mag[i] = umag(d[i]);
      if (mag[i] > m) m = mag[i];
      o.origin[i] = h.hit[i];
    end
    if (m == 0) begin
      res[0] = 0; res[1] = 0; res[2] = 0;
    end else begin
      while ((m << (s + 1)) < (u64_t'(1) << 31)) s++;
      for (int i = 0; i < 3; i++) begin
        mag[i] <<= s;
        sumsq += mag[i] * mag[i];
      end
      len = root(sumsq);
      for (int i = 0; i < 3; i++) begin
        q = ((mag[i] << 16) + len / 2) / len;
        if (q > u64_t'(ONE)) q = u64_t'(ONE);
        u[i] = d[i] < 0 ? -longint'(q) : longint'(q);
      end
      ior = longint'(ior_reg);
      if (ior < ONE) ior = ONE;
      if (ior > 4 * ONE) ior = 4 * ONE;
      eta = h.front ? longint'((u64_t'(ONE) * u64_t'(ONE) + u64_t'(ior) / 2) / u64_t'(ior))
                    : ior;
      dun = qmul(u[0], n[0]) + qmul(u[1], n[1]) + qmul(u[2], n[2]);
      cs = -dun;
      if (cs > ONE) cs = ONE;
      if (cs < -ONE) cs = -ONE;
      sin2 = ONE - qmul(cs, cs);
      if (sin2 < 0) sin2 = 0;
      sn = root(u64_t'(sin2) << 16);
      cannot = u64_t'(eta) * sn > u64_t'(ONE) * u64_t'(ONE);
      num = umag(ONE - eta);
      den = u64_t'(ONE + eta);
      r0l = longint'((num * u64_t'(ONE) + den / 2) / den);
      r0 = qmul(r0l, r0l);
      x = ONE - cs;
      p = x > ONE ? ONE : x;
      for (int i = 0; i < 4; i++) begin
        p = qmul(p, x);
        if (p > ONE) p = ONE;
      end
      refl = r0 + qmul(ONE - r0, p);
      beats = (u64_t'(refl) << 16) > (u64_t'(h.rnd) << 16);
      if (cannot || beats) begin
        o.refl = 1'b1;
        for (int i = 0; i < 3; i++) res[i] = clip32(u[i] - 2 * qmul(dun, n[i]));
      end else begin
        for (int i = 0; i < 3; i++) begin
          t = u[i] + qmul(cs, n[i]);
          perp[i] = clip32(qmul(eta, t));
          sq += umag(perp[i]) * umag(perp[i]);
        end
        lensq = (sq + HALF) >> 16;
        diff = lensq > u64_t'(ONE) ? lensq - u64_t'(ONE) : u64_t'(ONE) - lensq;
        par = root(diff << 16);
        for (int i = 0; i < 3; i++) res[i] = clip32(perp[i] - qmul(n[i], longint'(par)));
      end
    end
    for (int i = 0; i < 3; i++) o.dir[i] = res[i][31:0];
    return o;
  endfunction

  function void note_hit(ray_hit_t h);
    scatter_q.push_back(scatter(h));
    n_hits++;
  endfunction

  function void check_result(scatter_t got);
    scatter_t exp_r;
    bit       bad;
    n_results++;
    if (scatter_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t: result with nothing outstanding", $realtime);
      return;
    end
    exp_r = scatter_q.pop_front();
    if (exp_r.refl) n_refl++;
    bad = (got.refl !== exp_r.refl);
    for (int i = 0; i < 3; i++)
      bad |= (got.origin[i] !== exp_r.origin[i]) || (got.dir[i] !== exp_r.dir[i]);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"%0t: mismatch exp org %h %h %h dir %h %h %h r%b",
                  " / got org %h %h %h dir %h %h %h r%b"},
                 $realtime, exp_r.origin[0], exp_r.origin[1], exp_r.origin[2],
                 exp_r.dir[0], exp_r.dir[1], exp_r.dir[2], exp_r.refl,
                 got.origin[0], got.origin[1], got.origin[2],
                 got.dir[0], got.dir[1], got.dir[2], got.refl);
    end
  endfunction
endclass

module dielectric_reflect_refract_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY  = 94;
  localparam int N_RANDOM = 930;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [31:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic [17:0] normal_x_i = '0, normal_y_i = '0, normal_z_i = '0;
  logic        front_face_i = 1'b0;
  logic [15:0] random_value_i = '0;
  logic [31:0] hit_x_i = '0, hit_y_i = '0, hit_z_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [18:0] cfg_data_i = '0;
  logic        result_valid_o;
  logic [31:0] origin_x_o, origin_y_o, origin_z_o;
  logic [31:0] out_dir_x_o, out_dir_y_o, out_dir_z_o;
  logic        was_reflected_o;

  scatter_scoreboard sb = new();
  int hit_count;
  int index_writes;

  always #2 clk_i = ~clk_i;

  dielectric_reflect_refract uut (.*);

  // Results are strobes; sample them in the active region of the edge
  always @(posedge clk_i) begin
    scatter_t r;
    if (rst_ni && result_valid_o) begin
      r.origin[0] = origin_x_o;  r.origin[1] = origin_y_o;  r.origin[2] = origin_z_o;
      r.dir[0]    = out_dir_x_o; r.dir[1]    = out_dir_y_o; r.dir[2]    = out_dir_z_o;
      r.refl      = was_reflected_o;
      sb.check_result(r);
    end
  end

  // Present one hit and hold it until a transaction takes place.
  // start_i stays high on return so back-to-back hits need no second write.
  task automatic send_hit(ray_hit_t h);
    start_i        <= 1'b1;
    dir_x_i        <= h.dir[0]; dir_y_i    <= h.dir[1]; dir_z_i    <= h.dir[2];
    normal_x_i     <= h.nrm[0]; normal_y_i <= h.nrm[1]; normal_z_i <= h.nrm[2];
    front_face_i   <= h.front;
    random_value_i <= h.rnd;
    hit_x_i        <= h.hit[0]; hit_y_i    <= h.hit[1]; hit_z_i    <= h.hit[2];
    do @(posedge clk_i); while (busy_o);
    sb.note_hit(h);
    hit_count++;
  endtask

  task automatic idle_gap(int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Quiesce, then write the index; busy covers the set-up that follows
  task automatic write_index(logic [18:0] value);
    start_i <= 1'b0;
    while (sb.scatter_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.ior_reg = value;
    index_writes++;
  endtask

  function automatic logic [17:0] q16(real v);
    return 18'($rtoi(v * 65536.0 + (v < 0 ? -0.5 : 0.5)));
  endfunction

  // Unit normal from a random direction, rounded to signed Q2.16
  function automatic void unit_normal(ref logic [17:0] nrm [3]);
    real a[3];
    real l;
    do begin
      for (int i = 0; i < 3; i++) a[i] = real'(int'($urandom_range(0, 2000)) - 1000);
      l = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
    end while (l < 1.0);
    for (int i = 0; i < 3; i++) nrm[i] = q16(a[i] / l);
  endfunction

  function automatic ray_hit_t random_hit();
    ray_hit_t h;
    real      dot;
    int       sh;
    h.front = 1'($urandom_range(0, 1));
    h.rnd   = 16'($urandom);
    for (int i = 0; i < 3; i++) h.hit[i] = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      // noise: raw fields, normal components anywhere from -1.0 to 1.0
      for (int i = 0; i < 3; i++) begin
        h.dir[i] = $urandom;
        h.nrm[i] = 18'($signed($urandom_range(0, 131072)) - 65536);
      end
    end else begin
      unit_normal(h.nrm);
      sh = $urandom_range(1, 28);
      dot = 0.0;
      for (int i = 0; i < 3; i++) begin
        h.dir[i] = $signed($urandom) >>> sh;
        dot += real'($signed(h.dir[i])) * real'($signed(h.nrm[i]));
      end
      // outside hits travel against the normal, inside hits along it
      if ((h.front && dot > 0.0) || (!h.front && dot < 0.0))
        for (int i = 0; i < 3; i++) h.dir[i] = -h.dir[i];
    end
    return h;
  endfunction

  function automatic ray_hit_t make_hit(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                                        logic [17:0] nx, logic [17:0] ny, logic [17:0] nz,
                                        logic f, logic [15:0] r);
    ray_hit_t h;
    h.dir[0] = dx; h.dir[1] = dy; h.dir[2] = dz;
    h.nrm[0] = nx; h.nrm[1] = ny; h.nrm[2] = nz;
    h.front = f;
    h.rnd = r;
    for (int i = 0; i < 3; i++) h.hit[i] = $urandom;
    return h;
  endfunction

  task automatic random_phase(int count);
    int quiet_from;
    quiet_from = $urandom_range(0, count / 2);
    for (int k = 0; k < count; k++) begin
      send_hit(random_hit());
      // a long quiet stretch with back-to-back hits, otherwise ~27 % idling
      if ((k < quiet_from || k > quiet_from + count / 3) && $urandom_range(0, 99) < 27)
        idle_gap(1);
    end
  endtask

  localparam logic [31:0] P1 = 32'h0001_0000, M1 = 32'hFFFF_0000, DZ = 32'h0;
  localparam logic [17:0] NP = 18'h10000, NM = 18'h30000, NZ = 18'h0;

  initial begin
    ray_hit_t h;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_index(19'd98304);  // 1.5, glass-like
    // directed corners
    send_hit(make_hit(DZ, DZ, DZ, NZ, NP, NZ, 1'b1, 16'h0000));            // zero direction
    send_hit(make_hit(DZ, M1, DZ, NZ, NP, NZ, 1'b1, 16'hFFFF));            // head-on, front
    send_hit(make_hit(DZ, P1, DZ, NZ, NP, NZ, 1'b0, 16'hFFFF));            // head-on, back
    send_hit(make_hit(DZ, M1, DZ, NZ, NP, NZ, 1'b1, 16'h0000));            // random zero
    send_hit(make_hit(P1, 32'h0000_0100, DZ, NZ, NP, NZ, 1'b0, 16'hFFFF)); // grazing inside: TIR
    send_hit(make_hit(P1, 32'hFFFF_FF00, DZ, NZ, NP, NZ, 1'b1, 16'hFFFF)); // grazing outside
    send_hit(make_hit(32'h8000_0000, DZ, DZ, NP, NZ, NZ, 1'b0, 16'h1234)); // most negative
    send_hit(make_hit(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, NM, NM, NM, 1'b1, 16'h8000));
    send_hit(make_hit(32'd1, DZ, DZ, NM, NZ, NZ, 1'b1, 16'h7FFF));         // tiniest direction
    send_hit(make_hit(M1, M1, M1, NP, NP, NP, 1'b1, 16'h4000));            // non-unit normal
    send_hit(make_hit(P1, P1, P1, NP, NP, NP, 1'b0, 16'h4000));
    send_hit(make_hit(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, NP, NP, NP, 1'b0, 16'h0001));
    send_hit(make_hit(32'h0000_8000, 32'hFFFF_8000, 32'h7FFF_FFFF, NM, NP, NZ, 1'b0, 16'hC000));
    idle_gap(1);
    random_phase(N_RANDOM / 5);

    write_index(19'd262144); // top of range, strong reflection
    send_hit(make_hit(P1, 32'hFFFF_C000, DZ, NZ, NP, NZ, 1'b0, 16'h0100));
    random_phase(N_RANDOM / 5);

    write_index(19'd65536);  // matched index
    random_phase(N_RANDOM / 5);

    write_index(19'd0);      // below range
    random_phase(N_RANDOM / 10);

    write_index(19'h7FFFF);  // above range
    random_phase(N_RANDOM / 10);

    write_index(19'($urandom_range(65536, 262144)));
    random_phase(N_RANDOM / 5);

    start_i <= 1'b0;
    while (sb.scatter_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);

    $display("Covered %0d ray hits (%0d reflected) over %0d index settings incl. out-of-range.",
             sb.n_hits, sb.n_refl, index_writes);
    $display("Results checked: %0d, mismatches: %0d", sb.n_results, sb.mismatches);
    if (sb.mismatches == 0 && sb.scatter_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2ms;
    $display("Timed out with %0d results outstanding", sb.scatter_q.size());
    $display("FAIL");
    $finish;
  end

endmodule

/* dielectric_reflect_refract.f */
rtl/core/dlr_pkg.sv
rtl/core/dielectric_reflect_refract.sv
tb/dielectric_reflect_refract_test.sv
